[rtl/lrf_pkg.sv]
`default_nettype none

package lrf_pkg;

    localparam int DISPLAY_WIDTH = 128;
    localparam int PAGE_COUNT    = 8;
    localparam int ROW_COUNT     = PAGE_COUNT * 8;
    localparam int STORE_BYTES   = PAGE_COUNT * DISPLAY_WIDTH;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int COORD_W       = 8;
    localparam int DATA_W        = 8;
    localparam logic [DATA_W-1:0] PIXEL_BIT = 8'h01;

    typedef enum logic [1:0] {
        MODE_LINE   = 2'd0,
        MODE_TOGGLE = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_FETCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic advance;
    } t_step_ctrl;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_pixel;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_mem_wr;

endpackage

`default_nettype wire

[rtl/lrf_store.sv]
`default_nettype none

module lrf_store
    import lrf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_mem_wr           i_wr,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [STORE_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/lrf_line_step.sv]
`default_nettype none

module lrf_line_step
    import lrf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_step_ctrl         i_ctrl,
    input  wire logic [COORD_W-1:0] i_xa,
    input  wire logic [COORD_W-1:0] i_ya,
    input  wire logic [COORD_W-1:0] i_xb,
    input  wire logic [COORD_W-1:0] i_yb,
    output t_pixel                  o_pixel
);

    logic [COORD_W-1:0] r_major, r_end, r_minor, r_rem, r_dx;
    logic signed [COORD_W:0] r_d;
    logic r_steep;

    logic [COORD_W-1:0] dxa, dya;
    logic [COORD_W-1:0] a_maj, a_min, b_maj, b_min;
    logic [COORD_W-1:0] s_maj, s_min, e_maj, e_min;
    logic steep;
    logic signed [COORD_W+1:0] rem_sum;

    // endpoint setup: swap axes for steep lines, order along the major axis
    always_comb begin
        dxa   = (i_xa > i_xb) ? i_xa - i_xb : i_xb - i_xa;
        dya   = (i_ya > i_yb) ? i_ya - i_yb : i_yb - i_ya;
        steep = dxa < dya;
        a_maj = steep ? i_ya : i_xa;
        a_min = steep ? i_xa : i_ya;
        b_maj = steep ? i_yb : i_xb;
        b_min = steep ? i_xb : i_yb;
        if (a_maj > b_maj) begin
            s_maj = b_maj;
            s_min = b_min;
            e_maj = a_maj;
            e_min = a_min;
        end else begin
            s_maj = a_maj;
            s_min = a_min;
            e_maj = b_maj;
            e_min = b_min;
        end
    end

    assign rem_sum = $signed({2'b00, r_rem}) + $signed({r_d[COORD_W], r_d});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_major <= s_maj;
            r_end   <= e_maj;
            r_minor <= s_min;
            r_rem   <= '0;
            r_dx    <= e_maj - s_maj;
            r_d     <= $signed({1'b0, e_min}) - $signed({1'b0, s_min});
            r_steep <= steep;
        end else if (i_ctrl.advance) begin
            r_major <= r_major + 1'b1;
            // |d| <= dx keeps the remainder within one correction of [0, dx)
            if (rem_sum >= $signed({2'b00, r_dx})) begin
                r_rem   <= COORD_W'(rem_sum - $signed({2'b00, r_dx}));
                r_minor <= r_minor + 1'b1;
            end else if (rem_sum < 0) begin
                r_rem   <= COORD_W'(rem_sum + $signed({2'b00, r_dx}));
                r_minor <= r_minor - 1'b1;
            end else begin
                r_rem <= COORD_W'(rem_sum);
            end
        end
    end

    assign o_pixel.x    = r_steep ? r_minor : r_major;
    assign o_pixel.y    = r_steep ? r_major : r_minor;
    assign o_pixel.last = (r_major == r_end);

endmodule

`default_nettype wire

[rtl/line_raster_framebuffer.sv]
// channel   direction  handshake            payload
// in        sink       i_valid / o_stall    i_mode, i_x_start, i_y_start, i_x_end,
//                                           i_y_end, i_read_page, i_read_column
// out       source     o_valid / i_stall    o_read_data
//
// line: each plotted pixel is a read then a write of the byte store, up to
// 256 pixels; a toggle is a single-pixel line; read fetches one byte; clear
// writes one byte per cycle through the single write port.
// after reset a clearing pass runs before the first transfer.
// one item at a time; a finished result waits while the output register is
// full and i_stall is high, and the next item is accepted once it is loaded.
`default_nettype none

module line_raster_framebuffer
    import lrf_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [1:0]   i_mode,
    input  wire logic [7:0]   i_x_start,
    input  wire logic [7:0]   i_y_start,
    input  wire logic [7:0]   i_x_end,
    input  wire logic [7:0]   i_y_end,
    input  wire logic [2:0]   i_read_page,
    input  wire logic [6:0]   i_read_column,
    output logic              o_valid,
    output logic [7:0]        o_read_data,
    input  wire logic         i_stall
);

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic r_clr_item;
    logic r_rd_ok;
    logic [DATA_W-1:0] r_result;
    logic r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    t_mode in_mode;
    logic in_xfer, out_load, clr_last;
    t_step_ctrl step_ctrl;
    t_pixel pixel;
    t_mem_wr mem_wr;
    logic [ADDR_W-1:0] mem_raddr, pix_addr;
    logic [DATA_W-1:0] mem_rdata;
    logic pix_on;
    logic [COORD_W-1:0] end_x, end_y;

    assign in_mode  = t_mode'(i_mode);
    assign in_xfer  = i_valid && !o_stall;
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
    assign clr_last = (r_clr_addr == ADDR_W'(STORE_BYTES - 1));

    // a toggle is a single-point line
    assign end_x = (in_mode == MODE_TOGGLE) ? i_x_start : i_x_end;
    assign end_y = (in_mode == MODE_TOGGLE) ? i_y_start : i_y_end;

    assign pix_on   = (int'(pixel.x) < DISPLAY_WIDTH) && (int'(pixel.y) < ROW_COUNT);
    assign pix_addr = ADDR_W'(int'(pixel.y >> 3) * DISPLAY_WIDTH + int'(pixel.x));

    lrf_line_step u_step (
        .i_clk   (i_clk),
        .i_ctrl  (step_ctrl),
        .i_xa    (i_x_start),
        .i_ya    (i_y_start),
        .i_xb    (end_x),
        .i_yb    (end_y),
        .o_pixel (pixel)
    );

    lrf_store u_store (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (clr_last) n_state = r_clr_item ? ST_DONE : ST_IDLE;
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    unique case (in_mode)
                        MODE_LINE, MODE_TOGGLE: n_state = ST_RD;
                        MODE_CLEAR:             n_state = ST_CLEAR;
                        MODE_READ:              n_state = ST_FETCH;
                        default:                n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD:    n_state = ST_WR;
            ST_WR:    n_state = pixel.last ? ST_DONE : ST_RD;
            ST_FETCH: n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_stall           = (r_state != ST_IDLE);
        step_ctrl.load    = 1'b0;
        step_ctrl.advance = 1'b0;
        mem_wr.we         = 1'b0;
        mem_wr.addr       = pix_addr;
        mem_wr.data       = mem_rdata ^ (PIXEL_BIT << pixel.y[2:0]);
        mem_raddr         = pix_addr;
        unique case (r_state)
            ST_CLEAR: begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = r_clr_addr;
                mem_wr.data = '0;
            end
            ST_IDLE: begin
                step_ctrl.load = in_xfer;
                mem_raddr = ADDR_W'(int'(i_read_page) * DISPLAY_WIDTH + int'(i_read_column));
            end
            ST_WR: begin
                mem_wr.we         = pix_on;
                step_ctrl.advance = !pixel.last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + 1'b1;
                if (clr_last) r_clr_item <= 1'b0;
            end
            if (in_xfer && in_mode == MODE_CLEAR) r_clr_item <= 1'b1;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= '0;
            r_rd_ok  <= (int'(i_read_page) < PAGE_COUNT)
                     && (int'(i_read_column) < DISPLAY_WIDTH);
        end else if (r_state == ST_FETCH) begin
            r_result <= r_rd_ok ? mem_rdata : '0;
        end
        if (out_load) r_out_data <= r_result;
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_stall)
        else $error("input transfer did not leave the block busy");

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) |-> ($past(r_state) == ST_RD))
        else $error("pixel write without a preceding store read");

    a_no_step_past_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_ctrl.advance |-> !pixel.last)
        else $error("line walk advanced past its end point");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_state == ST_IDLE) && o_valid)
        else $error("result load did not return to idle");

endmodule

`default_nettype wire

[bench/line_raster_framebuffer_test.sv]
`default_nettype none

module line_raster_framebuffer_test;
    import lrf_pkg::*;

    localparam int STALL_PCT    = 22;
    localparam int HOLD_CYCLES  = 3000;
    localparam int WDOG_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 1100;
    localparam int RANDOM_ITEMS = 530;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_mode      i_mode = MODE_LINE;
    logic [7:0] i_x_start = '0;
    logic [7:0] i_y_start = '0;
    logic [7:0] i_x_end = '0;
    logic [7:0] i_y_end = '0;
    logic [2:0] i_read_page = '0;
    logic [6:0] i_read_column = '0;
    logic       o_valid;
    logic [7:0] o_read_data;
    logic       i_stall = 1'b0;

    line_raster_framebuffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_read_page   (i_read_page),
        .i_read_column (i_read_column),
        .o_valid       (o_valid),
        .o_read_data   (o_read_data),
        .i_stall       (i_stall)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the pixel store and expected read bytes
    logic [DATA_W-1:0] pixel_bytes [STORE_BYTES];
    logic [DATA_W-1:0] read_data_queue [$];
    t_mode             mode_queue [$];

    int  errors = 0;
    int  n_lines = 0;
    int  n_toggles = 0;
    int  n_clears = 0;
    int  n_reads = 0;
    int  n_nonzero_reads = 0;
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    logic [7:0] last_x = '0;
    logic [7:0] last_y = '0;

    function automatic void xor_pixel(int unsigned x, int unsigned y);
        if (x < DISPLAY_WIDTH && y < ROW_COUNT)
            pixel_bytes[ADDR_W'((y >> 3) * DISPLAY_WIDTH + x)] ^= PIXEL_BIT << (y & 7);
    endfunction

    function automatic int unsigned abs_gap(int unsigned a, int unsigned b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic void rasterize_line(int unsigned xa, int unsigned ya,
                                           int unsigned xb, int unsigned yb);
        bit          steep;
        int unsigned t;
        int unsigned run;
        int unsigned major;
        int unsigned minor;
        steep = abs_gap(xa, xb) < abs_gap(ya, yb);
        if (steep) begin
            t = xa; xa = ya; ya = t;
            t = xb; xb = yb; yb = t;
        end
        if (xa > xb) begin
            t = xa; xa = xb; xb = t;
            t = ya; ya = yb; yb = t;
        end
        run = xb - xa;
        if (run == 0) begin
            xor_pixel(xa, ya);
            return;
        end
        for (major = xa; major <= xb; major++) begin
            // weighted form of the endpoint interpolation, never negative
            minor = (ya * (xb - major) + yb * (major - xa)) / run;
            if (steep)
                xor_pixel(minor, major);
            else
                xor_pixel(major, minor);
        end
    endfunction

    function automatic logic [7:0] predict_read_data(t_mode m, logic [7:0] xs,
            logic [7:0] ys, logic [7:0] xe, logic [7:0] ye, logic [2:0] pg,
            logic [6:0] col);
        logic [7:0] data;
        data = '0;
        case (m)
            MODE_LINE:   rasterize_line(32'(xs), 32'(ys), 32'(xe), 32'(ye));
            MODE_TOGGLE: xor_pixel(32'(xs), 32'(ys));
            MODE_CLEAR:  foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
            MODE_READ:   data = pixel_bytes[ADDR_W'(int'(pg) * DISPLAY_WIDTH + int'(col))];
            default:     data = '0;
        endcase
        return data;
    endfunction

    // result check first, then prediction of the transfer taken this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (read_data_queue.size() == 0) begin
                    $error("read_data: unexpected result %0h", o_read_data);
                    errors++;
                end else begin
                    if (o_read_data !== read_data_queue[0]) begin
                        $error("read_data mismatch: expected %0h actual %0h",
                               read_data_queue[0], o_read_data);
                        errors++;
                    end else if (mode_queue[0] == MODE_READ && o_read_data != 0) begin
                        n_nonzero_reads++;
                    end
                    void'(read_data_queue.pop_front());
                    void'(mode_queue.pop_front());
                end
            end
            if (i_valid && !o_stall) begin
                read_data_queue.push_back(predict_read_data(i_mode, i_x_start,
                    i_y_start, i_x_end, i_y_end, i_read_page, i_read_column));
                mode_queue.push_back(i_mode);
                case (i_mode)
                    MODE_LINE:   n_lines++;
                    MODE_TOGGLE: n_toggles++;
                    MODE_CLEAR:  n_clears++;
                    default:     n_reads++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !no_idle && ($urandom_range(99) < STALL_PCT);
        end
    end

    task automatic send_op(t_mode m, logic [7:0] xs, logic [7:0] ys, logic [7:0] xe,
                           logic [7:0] ye, logic [2:0] pg, logic [6:0] col);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < STALL_PCT)
            gap = $urandom_range(4, 1);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_mode        <= m;
        i_x_start     <= xs;
        i_y_start     <= ys;
        i_x_end       <= xe;
        i_y_end       <= ye;
        i_read_page   <= pg;
        i_read_column <= col;
        i_valid       <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_read(logic [2:0] pg, logic [6:0] col);
        send_op(MODE_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                pg, col);
    endtask

    task automatic send_toggle(logic [7:0] x, logic [7:0] y);
        send_op(MODE_TOGGLE, x, y, 8'($urandom), 8'($urandom), 3'($urandom),
                7'($urandom));
    endtask

    task automatic send_line(logic [7:0] xs, logic [7:0] ys, logic [7:0] xe,
                             logic [7:0] ye);
        send_op(MODE_LINE, xs, ys, xe, ye, 3'($urandom), 7'($urandom));
    endtask

    function automatic logic [7:0] pick_coord(int unsigned lim);
        if ($urandom_range(99) < 85)
            return 8'($urandom_range(lim));
        return 8'($urandom_range(255));
    endfunction

    task automatic test_directed();
        send_read(3'd0, 7'd0);
        send_toggle(8'd0, 8'd0);
        send_read(3'd0, 7'd0);
        send_toggle(8'd127, 8'd63);
        send_read(3'd7, 7'd127);
        // pixels just past the right and bottom borders, and the far corner
        send_toggle(8'd128, 8'd5);
        send_toggle(8'd5, 8'd64);
        send_toggle(8'd255, 8'd255);
        send_line(8'd0, 8'd0, 8'd7, 8'd0);
        send_read(3'd0, 7'd0);
        send_read(3'd0, 7'd3);
        // vertical, given bottom to top
        send_line(8'd10, 8'd7, 8'd10, 8'd0);
        send_read(3'd0, 7'd10);
        send_line(8'd20, 8'd3, 8'd20, 8'd3);
        send_read(3'd0, 7'd20);
        send_line(8'd30, 8'd0, 8'd33, 8'd9);
        send_read(3'd1, 7'd33);
        send_line(8'd120, 8'd60, 8'd200, 8'd70);
        send_read(3'd7, 7'd120);
        send_line(8'd255, 8'd0, 8'd0, 8'd255);
        send_line(8'd100, 8'd40, 8'd90, 8'd50);
        send_op(MODE_CLEAR, 8'hff, 8'hff, 8'hff, 8'hff, 3'd7, 7'd127);
        send_read(3'd7, 7'd127);
        send_toggle(8'd64, 8'd32);
        send_read(3'd4, 7'd64);
    endtask

    // receiver holds off while items keep coming, so the block backs up
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) begin
            case (i % 3)
                0: send_line(pick_coord(127), pick_coord(63), pick_coord(127),
                             pick_coord(63));
                1: send_toggle(pick_coord(127), pick_coord(63));
                default: send_read(3'($urandom), 7'($urandom));
            endcase
        end
    endtask

    task automatic test_random();
        int         sel;
        logic [7:0] xs;
        logic [7:0] ys;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = (i >= 200 && i < 290);
            sel = $urandom_range(99);
            xs = pick_coord(127);
            ys = pick_coord(63);
            if (sel < 35) begin
                send_line(xs, ys, pick_coord(127), pick_coord(63));
                last_x = xs;
                last_y = ys;
            end else if (sel < 60) begin
                send_toggle(xs, ys);
                last_x = xs;
                last_y = ys;
            end else if (sel < 99) begin
                // half the reads look where something was just drawn
                if ($urandom_range(1))
                    send_read(last_y[5:3], last_x[6:0]);
                else
                    send_read(3'($urandom), 7'($urandom));
            end else begin
                send_op(MODE_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 3'($urandom), 7'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (read_data_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        errors += read_data_queue.size();
        $display("covered %0d lines, %0d pixel toggles, %0d clears, %0d byte reads",
                 n_lines, n_toggles, n_clears, n_reads);
        $display("%0d reads returned set pixels, with a %0d-cycle output hold-off",
                 n_nonzero_reads, HOLD_CYCLES);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
